[rtl/olir_pkg.sv]
// ----------------------------------------------------------------------------
// olir_pkg
// Shared types and codes for the ordered list with positional insert and
// remove.
// ----------------------------------------------------------------------------
package olir_pkg;

  // Operation codes carried in the command field.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned ValueW = 32;

  // Shift control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // open a gap at the position and write the new value
    logic rem;  // close the gap at the position
  } shift_ctl_t;

endpackage

[rtl/olir_cell.sv]
// ----------------------------------------------------------------------------
// olir_cell
// One storage cell of the list chain. It compares its own index with the
// operation position and takes data from its left or right neighbour.
// ----------------------------------------------------------------------------
module olir_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 5
) (
  input  logic                                clk_i,
  input  olir_pkg::shift_ctl_t                ctl_i,
  input  logic [CntW-1:0]                     pos_i,
  input  logic [olir_pkg::ValueW-1:0]         value_i,
  input  logic [olir_pkg::ValueW-1:0]         left_i,
  input  logic [olir_pkg::ValueW-1:0]         right_i,
  output logic [olir_pkg::ValueW-1:0]         data_o,
  output logic [olir_pkg::ValueW-1:0]         hit_data_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(Index);

  logic [olir_pkg::ValueW-1:0] data_q, data_d;
  logic                        at_pos;
  logic                        above_pos;

  assign at_pos    = (pos_i == MyIdx);
  assign above_pos = (MyIdx > pos_i);

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (above_pos) begin
        data_d = left_i;
      end else if (at_pos) begin
        data_d = value_i;
      end
    end else if (ctl_i.rem) begin
      if (above_pos || at_pos) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  // Only the cell at the position drives its value onto the read-out OR tree.
  assign hit_data_o = at_pos ? data_q : '0;

endmodule

[rtl/ordered_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_remove
// Bounded ordered list held in a chain of cells that all shift in parallel.
// ----------------------------------------------------------------------------
// The result of each input transfer is registered before it appears on the output.
// Throughput: one operation per cycle while the output is not stalled; every cell
// shifts in the same cycle, so the chain update and the registered result set the figure.
// A new item is taken while the result register is empty or being drained.
// Reset empties the list; cell contents are not cleared and are never read
// beyond the count.
module ordered_list_insert_remove #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // cmd, position, value (low bit up)
  input  logic [((1+$clog2(CAPACITY+1)+32+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status, removed_value, count (low bit up)
  output logic [((2+32+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned VW   = olir_pkg::ValueW;
  localparam int unsigned OutW = ((2 + VW + CntW + 7) / 8) * 8;
  localparam logic [CntW-1:0] Full = CntW'(CAPACITY);

  logic            in_cmd;
  logic [CntW-1:0] in_pos;
  logic [VW-1:0]   in_value;

  assign in_cmd   = s_axis_tdata_i[0];
  assign in_pos   = s_axis_tdata_i[CntW:1];
  assign in_value = s_axis_tdata_i[CntW+VW:CntW+1];

  logic [CntW-1:0]      count_q, count_d;
  logic                 out_valid_q;
  olir_pkg::status_e    status_q, status_d;
  logic [VW-1:0]        removed_q, removed_d;
  logic [CntW-1:0]      out_count_q;
  logic                 accept;
  olir_pkg::shift_ctl_t ctl;

  logic [VW-1:0] cell_data [CAPACITY];
  logic [VW-1:0] cell_hit  [CAPACITY];
  logic [VW-1:0] hit_value;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | cell_hit[i];
    end
  end

  always_comb begin
    ctl       = '0;
    count_d   = count_q;
    status_d  = olir_pkg::ST_DONE;
    removed_d = '0;
    if (in_cmd == olir_pkg::CMD_INSERT) begin
      if (in_pos > count_q) begin
        status_d = olir_pkg::ST_RANGE;
      end else if (count_q == Full) begin
        status_d = olir_pkg::ST_FULL;
      end else begin
        ctl.ins = accept;
        count_d = count_q + 1'b1;
      end
    end else begin
      if (in_pos >= count_q) begin
        status_d = olir_pkg::ST_RANGE;
      end else begin
        ctl.rem   = accept;
        count_d   = count_q - 1'b1;
        removed_d = hit_value;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    olir_cell #(
      .Index (g),
      .CntW  (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .pos_i      (in_pos),
      .value_i    (in_value),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (cell_data[g]),
      .hit_data_o (cell_hit[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      removed_q   <= removed_d;
      out_count_q <= count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutW'({out_count_q, removed_q, status_q});

endmodule

[tb/sv/tb_ordered_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_remove
// Self-checking testbench for the bounded ordered list. Every accepted
// operation is applied to a shadow copy of the list, and the expected status,
// removed value and count are queued. Each result transfer on the output is
// compared field by field with the oldest queued entry. Directed tests cover
// the empty list, filling to capacity and draining to empty. Random phases
// then sweep the list between empty and full under varying input gaps and
// output stalls, with one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_remove;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP           = 16;
  localparam int POS_W         = $clog2(CAP + 1);
  localparam int IN_W          = ((1 + POS_W + 32 + 7) / 8) * 8;
  localparam int OUT_W         = ((2 + 32 + POS_W + 7) / 8) * 8;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    olir_pkg::status_e  status;
    logic [31:0]        removed;
    logic [POS_W-1:0]   count;
  } list_result_t;

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             s_valid = 1'b0;
  logic [IN_W-1:0]  s_data  = '0;
  logic             s_ready;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [OUT_W-1:0] m_data;

  // Shadow copy of the list, updated when an operation is accepted.
  logic [31:0]  shadow_entries [CAP];
  int           shadow_count = 0;
  bit           filling      = 1'b1;

  list_result_t pending_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int stall_cycles   = 0;

  int errors     = 0;
  int n_inserts  = 0;
  int n_removes  = 0;
  int n_results  = 0;
  int n_full     = 0;
  int n_range    = 0;
  int peak_count = 0;
  int n_blocked  = 0;

  ordered_list_insert_remove #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Applies one operation to the shadow list and returns the result it gives.
  function automatic list_result_t apply_list_op(logic cmd, logic [POS_W-1:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    int           i;
    int           p;
    r.status  = olir_pkg::ST_DONE;
    r.removed = '0;
    p = int'(pos);
    if (cmd == olir_pkg::CMD_INSERT) begin
      if (p > shadow_count) begin
        r.status = olir_pkg::ST_RANGE;
      end else if (shadow_count >= CAP) begin
        r.status = olir_pkg::ST_FULL;
      end else begin
        for (i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[p] = val;
        shadow_count++;
      end
    end else begin
      if (p >= shadow_count) begin
        r.status = olir_pkg::ST_RANGE;
      end else begin
        r.removed = shadow_entries[p];
        for (i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
        shadow_count--;
      end
    end
    r.count = shadow_count[POS_W-1:0];
    return r;
  endfunction

  // Offers one operation and waits for its transfer. The valid line is left
  // high so that back-to-back items follow without a gap.
  task automatic send_item(input logic cmd, input logic [POS_W-1:0] pos,
                           input logic [31:0] val);
    list_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(IN_W - 1 - POS_W - 32){1'b0}}, val, pos, cmd};
    do @(posedge clk_i); while (s_ready !== 1'b1);
    r = apply_list_op(cmd, pos, val);
    pending_results.push_back(r);
    if (cmd == olir_pkg::CMD_INSERT) n_inserts++;
    else n_removes++;
    if (r.status == olir_pkg::ST_FULL) n_full++;
    if (r.status == olir_pkg::ST_RANGE) n_range++;
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  task automatic release_input();
    s_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed operations that sweep the list between empty and full,
  // with some operations at arbitrary positions mixed in.
  task automatic run_random_ops(input int n);
    int               k;
    logic             cmd;
    logic [POS_W-1:0] pos;
    for (k = 0; k < n; k++) begin
      if (shadow_count >= CAP) filling = 1'b0;
      if (shadow_count == 0) filling = 1'b1;
      if ($urandom_range(99) < 12) begin
        cmd = 1'($urandom_range(1));
        pos = POS_W'($urandom_range(31));
      end else begin
        cmd = ($urandom_range(99) < (filling ? 70 : 30)) ? olir_pkg::CMD_INSERT
                                                         : olir_pkg::CMD_REMOVE;
        if (shadow_count == 0) cmd = olir_pkg::CMD_INSERT;
        if (cmd == olir_pkg::CMD_INSERT) pos = POS_W'($urandom_range(shadow_count));
        else pos = POS_W'($urandom_range(shadow_count - 1));
      end
      send_item(cmd, pos, pick_value());
    end
  endtask

  task automatic test_empty_list();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(olir_pkg::CMD_REMOVE, 5'd0, 32'h1234_5678);
    send_item(olir_pkg::CMD_REMOVE, 5'd31, 32'hffff_ffff);
    send_item(olir_pkg::CMD_INSERT, 5'd1, 32'h0bad_cafe);
    send_item(olir_pkg::CMD_INSERT, 5'd31, 32'h8000_0000);
    release_input();
  endtask

  task automatic test_fill_to_capacity();
    int k;
    send_item(olir_pkg::CMD_INSERT, 5'd0, 32'h8000_0000);
    send_item(olir_pkg::CMD_INSERT, 5'd1, 32'h7fff_ffff);
    for (k = 0; k < CAP - 2; k++) begin
      case (k % 3)
        0:       send_item(olir_pkg::CMD_INSERT, 5'd0, $urandom);
        1:       send_item(olir_pkg::CMD_INSERT, shadow_count[POS_W-1:0], $urandom);
        default: send_item(olir_pkg::CMD_INSERT, POS_W'(shadow_count / 2), $urandom);
      endcase
    end
    // A full list refuses positions in range; a position out of range wins.
    send_item(olir_pkg::CMD_INSERT, 5'd5, 32'h5555_aaaa);
    send_item(olir_pkg::CMD_INSERT, 5'd16, 32'haaaa_5555);
    send_item(olir_pkg::CMD_INSERT, 5'd17, 32'h0000_0001);
    send_item(olir_pkg::CMD_INSERT, 5'd31, 32'hffff_ffff);
    send_item(olir_pkg::CMD_REMOVE, 5'd16, 32'h0);
    release_input();
  endtask

  // Removes from head, tail and middle in turn down to the only entry, then once more when empty.
  task automatic test_drain_to_empty();
    int k;
    k = 0;
    while (shadow_count > 0) begin
      case (k % 3)
        0:       send_item(olir_pkg::CMD_REMOVE, 5'd0, $urandom);
        1:       send_item(olir_pkg::CMD_REMOVE, POS_W'(shadow_count - 1), $urandom);
        default: send_item(olir_pkg::CMD_REMOVE, POS_W'(shadow_count / 2), $urandom);
      endcase
      k++;
    end
    send_item(olir_pkg::CMD_REMOVE, 5'd0, 32'h0);
    release_input();
  endtask

  task automatic test_no_idling();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_ops(400);
    release_input();
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 64;
    recv_stall_pct = 0;
    run_random_ops(400);
    release_input();
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 64;
    run_random_ops(400);
    release_input();
  endtask

  task automatic test_both_idling();
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    run_random_ops(400);
    release_input();
  endtask

  // The output is held off for a long stretch while items keep coming, so the
  // result register fills and the input must stall until the hold ends.
  task automatic test_output_held_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    run_random_ops(60);
    release_input();
  endtask

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_ready <= 1'b0;
      hold_left--;
      if (s_valid && !s_ready) n_blocked++;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && m_valid && m_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no operation outstanding: tdata %h", m_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_data[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_data[1:0]);
          errors++;
        end
        if (m_data[33:2] !== want.removed) begin
          $error("removed_value: expected %0d, got %0d",
                 $signed(want.removed), $signed(m_data[33:2]));
          errors++;
        end
        if (m_data[34 +: POS_W] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, m_data[34 +: POS_W]);
          errors++;
        end
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_MAX) begin
      $display("tb_ordered_list_insert_remove: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_fill_to_capacity();
    test_drain_to_empty();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idling();
    test_output_held_off();

    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Covered %0d inserts and %0d removes with %0d results checked;",
             n_inserts, n_removes, n_results);
    $display("list reached %0d of %0d entries, %0d full and %0d range rejects,",
             peak_count, CAP, n_full, n_range);
    $display("input blocked %0d cycles.", n_blocked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_ordered_list_insert_remove: PASS");
    end else begin
      $display("tb_ordered_list_insert_remove: FAIL");
    end
    $finish;
  end

endmodule
